@@ sv/hex_text_image_parser_macros.svh @@
// assertion macros of the hex text image parser rtl
// no dependencies; included by files that carry concurrent assertions
`ifndef HEX_TEXT_IMAGE_PARSER_MACROS_SVH
`define HEX_TEXT_IMAGE_PARSER_MACROS_SVH

// antecedent implies consequent in the same cycle
`define HTIP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define HTIP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/htip_pkg.sv @@
// types, constants and character helpers of the hex text image parser
// no dependencies; used by the channel interfaces and the top level
package htip_pkg;

  localparam int CHAR_W      = 8;
  localparam int CAP_W       = 16;
  localparam int OUT_COUNT_W = 16;
  localparam int COUNT_BITS  = 16;
  localparam int CMP_W       = (COUNT_BITS > CAP_W) ? COUNT_BITS : CAP_W;
  localparam int PREFIX_LEN  = 7;
  localparam int POS_W       = 3;

  localparam logic [CAP_W-1:0]        CAP_RESET  = 16'h4000;
  localparam logic [COUNT_BITS-1:0]   COUNT_MAX  = '1;
  localparam logic [PREFIX_LEN*8-1:0] MAGIC      = "MARSHEX";
  localparam logic [CHAR_W-1:0]       CHAR_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0]       CHAR_MAGIC0 = "M";

  typedef enum logic [1:0] {
    PH_LEAD   = 2'd0,
    PH_PREFIX = 2'd1,
    PH_BODY   = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_OK   = 2'd1,
    KIND_FAIL = 2'd2
  } kind_t;

  // space, tab, line feed, carriage return
  function automatic logic is_space(input logic [CHAR_W-1:0] c);
    return (c == 8'h20) || (c == 8'h09) || (c == 8'h0A) || (c == 8'h0D);
  endfunction

  // bit 4 set means not a hex digit
  function automatic logic [4:0] hex_value(input logic [CHAR_W-1:0] c);
    logic [4:0] v;
    if (c >= "0" && c <= "9") begin
      v = 5'(c - "0");
    end else if (c >= "a" && c <= "f") begin
      v = 5'(c - "a" + 8'd10);
    end else if (c >= "A" && c <= "F") begin
      v = 5'(c - "A" + 8'd10);
    end else begin
      v = 5'h10;
    end
    return v;
  endfunction

  // letter of the magic prefix at a position, first letter at zero
  function automatic logic [CHAR_W-1:0] magic_char(input logic [POS_W-1:0] pos);
    logic [CHAR_W-1:0] ch;
    ch = CHAR_NUL;
    for (int i = 0; i < PREFIX_LEN; i++) begin
      if (int'(pos) == i) begin
        ch = MAGIC[(PREFIX_LEN-1-i)*8 +: 8];
      end
    end
    return ch;
  endfunction

endpackage

@@ sv/htip_ifs.sv @@
// valid/ready channel interfaces of the hex text image parser
// depends on htip_pkg for payload widths
interface htip_in_if;
  logic                        valid;
  logic                        ready;
  logic [htip_pkg::CHAR_W-1:0] text_char;

  modport source (output valid, output text_char, input ready);
  modport sink   (input valid, input text_char, output ready);
endinterface

interface htip_out_if;
  logic                             valid;
  logic                             ready;
  logic [1:0]                       kind;
  logic [htip_pkg::CHAR_W-1:0]      data_byte;
  logic [htip_pkg::OUT_COUNT_W-1:0] byte_count;

  modport source (output valid, output kind, output data_byte, output byte_count,
                  input ready);
  modport sink   (input valid, input kind, input data_byte, input byte_count,
                  output ready);
endinterface

interface htip_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [htip_pkg::CAP_W-1:0] byte_capacity;

  modport source (output valid, output byte_capacity, input ready);
  modport sink   (input valid, input byte_capacity, output ready);
endinterface

@@ sv/hex_text_image_parser.sv @@
// top level of the hex text image parser: input register, parse logic, result register
// depends on htip_pkg, the channel interfaces in htip_ifs.sv and the assertion macros
`include "hex_text_image_parser_macros.svh"

// Takes a text one character per transaction on in_chan; a zero character ends
// the text. Leading whitespace is skipped, an optional "MARSHEX" prefix may stand
// at the first non-space position, then pairs of hex digits (either case) follow,
// with whitespace only between pairs. Each pair gives a data-byte transaction on
// out_chan carrying the running byte count; the terminator gives one verdict
// transaction (ok with the final count, or fail with the count reached before
// the failure) and the parser rearms for the next text. After a failure nothing
// is sent until the terminator. Rate: one character per clock, sustained, with
// both sides streaming; a character waits in the input register until it is
// consumed, and its result (if any) shows on out_chan from the next cycle, held
// in the result register until taken. The parse state update for one character
// is the only loop, closed through the parse state registers. byte_capacity
// (cfg_chan, reset 0x4000) may be written only while the parser is idle.
module hex_text_image_parser (
  input  logic              clk,
  input  logic              rst_n,
  htip_in_if.sink           in_chan,
  htip_out_if.source        out_chan,
  htip_cfg_if.sink          cfg_chan
);

  // configuration register
  logic [htip_pkg::CAP_W-1:0] cap_r;

  // input register
  logic                        in_valid_r;
  logic [htip_pkg::CHAR_W-1:0] in_char_r;

  // parse state
  htip_pkg::phase_t                phase_r, phase_nxt;
  logic [htip_pkg::POS_W-1:0]      pos_r, pos_nxt;
  logic [3:0]                      high_r, high_nxt;
  logic                            have_high_r, have_high_nxt;
  logic [htip_pkg::COUNT_BITS-1:0] count_r, count_nxt;
  logic                            failed_r, failed_nxt;

  // result register
  logic                             out_valid_r;
  htip_pkg::kind_t                  out_kind_r, res_kind;
  logic [htip_pkg::CHAR_W-1:0]      out_byte_r, res_byte;
  logic [htip_pkg::OUT_COUNT_W-1:0] out_count_r, res_count;
  logic                             res_valid;

  // character decode
  logic                            proc_fire;
  logic                            is_term;
  logic                            is_sp;
  logic [4:0]                      hv;
  logic                            is_hex;
  logic                            do_body;
  logic                            cap_full;
  logic                            body_emit;
  logic [htip_pkg::COUNT_BITS-1:0] count_inc;
  logic                            verdict_ok;

  // the character in the input register is consumed when the result register
  // is free or is being emptied in this cycle
  assign proc_fire = in_valid_r && (!out_valid_r || out_chan.ready);
  assign in_chan.ready = !in_valid_r || proc_fire;
  assign cfg_chan.ready = 1'b1;

  assign is_term = (in_char_r == htip_pkg::CHAR_NUL);
  assign is_sp   = htip_pkg::is_space(in_char_r);
  assign hv      = htip_pkg::hex_value(in_char_r);
  assign is_hex  = !hv[4];

  // character goes to the hex body logic: body phase, or first non-space
  // character in the leading phase that does not open the prefix
  always_comb begin
    do_body = 1'b0;
    if (!is_term && !failed_r) begin
      unique case (phase_r)
        htip_pkg::PH_LEAD:   do_body = !is_sp && (in_char_r != htip_pkg::CHAR_MAGIC0);
        htip_pkg::PH_PREFIX: do_body = 1'b0;
        default:             do_body = 1'b1;
      endcase
    end
  end

  // refuse a byte beyond the capacity or beyond the counter range
  assign cap_full  = (htip_pkg::CMP_W'(count_r) >= htip_pkg::CMP_W'(cap_r))
                  || (count_r == htip_pkg::COUNT_MAX);
  assign count_inc = count_r + 1'b1;
  assign body_emit = do_body && have_high_r && is_hex && !cap_full;

  // verdict: no failure, body reached, no lone digit, at least one byte
  assign verdict_ok = !failed_r && (phase_r != htip_pkg::PH_LEAD)
                   && (phase_r != htip_pkg::PH_PREFIX) && !have_high_r
                   && (count_r != '0);

  // next parse state
  always_comb begin
    phase_nxt     = phase_r;
    pos_nxt       = pos_r;
    high_nxt      = high_r;
    have_high_nxt = have_high_r;
    count_nxt     = count_r;
    failed_nxt    = failed_r;
    if (is_term) begin
      // rearm after any verdict
      phase_nxt     = htip_pkg::PH_LEAD;
      pos_nxt       = '0;
      high_nxt      = '0;
      have_high_nxt = 1'b0;
      count_nxt     = '0;
      failed_nxt    = 1'b0;
    end else if (!failed_r) begin
      unique case (phase_r)
        htip_pkg::PH_LEAD: begin
          if (!is_sp) begin
            if (in_char_r == htip_pkg::CHAR_MAGIC0) begin
              phase_nxt = htip_pkg::PH_PREFIX;
              pos_nxt   = htip_pkg::POS_W'(1);
            end else begin
              phase_nxt = htip_pkg::PH_BODY;
            end
          end
        end
        htip_pkg::PH_PREFIX: begin
          if ((int'(pos_r) >= htip_pkg::PREFIX_LEN)
              || (in_char_r != htip_pkg::magic_char(pos_r))) begin
            failed_nxt = 1'b1;
          end else begin
            pos_nxt = pos_r + 1'b1;
            if (int'(pos_r) + 1 >= htip_pkg::PREFIX_LEN) begin
              phase_nxt = htip_pkg::PH_BODY;
            end
          end
        end
        default: ;
      endcase
      if (do_body) begin
        if (!have_high_r) begin
          // first digit of a pair; whitespace is fine between pairs
          if (!is_sp) begin
            if (!is_hex) begin
              failed_nxt = 1'b1;
            end else begin
              high_nxt      = hv[3:0];
              have_high_nxt = 1'b1;
            end
          end
        end else if (!is_hex || cap_full) begin
          // bad second digit, whitespace inside a pair, or no room left
          failed_nxt = 1'b1;
        end else begin
          count_nxt     = count_inc;
          have_high_nxt = 1'b0;
          high_nxt      = '0;
        end
      end
    end
  end

  // result of the current character
  always_comb begin
    res_valid = 1'b0;
    res_kind  = htip_pkg::KIND_DATA;
    res_byte  = '0;
    res_count = htip_pkg::OUT_COUNT_W'(count_r);
    if (is_term) begin
      res_valid = 1'b1;
      res_kind  = verdict_ok ? htip_pkg::KIND_OK : htip_pkg::KIND_FAIL;
    end else if (body_emit) begin
      res_valid = 1'b1;
      res_byte  = {high_r, hv[3:0]};
      res_count = htip_pkg::OUT_COUNT_W'(count_inc);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r       <= htip_pkg::CAP_RESET;
      in_valid_r  <= 1'b0;
      phase_r     <= htip_pkg::PH_LEAD;
      pos_r       <= '0;
      high_r      <= '0;
      have_high_r <= 1'b0;
      count_r     <= '0;
      failed_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_chan.valid) begin
        cap_r <= cfg_chan.byte_capacity;
      end
      if (in_chan.ready) begin
        in_valid_r <= in_chan.valid;
      end
      if (proc_fire) begin
        phase_r     <= phase_nxt;
        pos_r       <= pos_nxt;
        high_r      <= high_nxt;
        have_high_r <= have_high_nxt;
        count_r     <= count_nxt;
        failed_r    <= failed_nxt;
      end
      if (proc_fire && res_valid) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      in_char_r <= in_chan.text_char;
    end
    if (proc_fire && res_valid) begin
      out_kind_r  <= res_kind;
      out_byte_r  <= res_byte;
      out_count_r <= res_count;
    end
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.kind       = out_kind_r;
  assign out_chan.data_byte  = out_byte_r;
  assign out_chan.byte_count = out_count_r;

  // a data byte never lies beyond the capacity and never has a zero count
  `HTIP_ASSERT_NOW(a_data_in_capacity, clk, rst_n,
    out_valid_r && (out_kind_r == htip_pkg::KIND_DATA),
    (out_count_r != '0) && (out_count_r <= cap_r), "data byte beyond capacity")
  // a terminator leaves the parse state rearmed
  `HTIP_ASSERT_NEXT(a_rearm, clk, rst_n, proc_fire && is_term,
    (phase_r == htip_pkg::PH_LEAD) && (count_r == '0) && !failed_r && !have_high_r,
    "parser not rearmed after verdict")
  // once failed, a non-terminator leaves nothing in the result register
  `HTIP_ASSERT_NEXT(a_silent_after_fail, clk, rst_n, proc_fire && failed_r && !is_term,
    !out_valid_r, "result sent after failure")
  // a pending first digit exists only in the hex body
  `HTIP_ASSERT_NOW(a_digit_in_body, clk, rst_n, have_high_r,
    (phase_r != htip_pkg::PH_LEAD) && (phase_r != htip_pkg::PH_PREFIX),
    "pending digit outside hex body")

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 100ps
// self-checking testbench of the hex text image parser: directed and random texts
// depends on htip_pkg, the channel interfaces in htip_ifs.sv and hex_text_image_parser
module testbench;

  localparam int HALF_PERIOD   = 6;     // 12 ns clock
  localparam int MAX_WAIT      = 12;    // longest random gap or stall, in cycles
  localparam int STALL_LIMIT   = 1000;  // cycles without any transaction before giving up
  localparam int SETTLE_CYCLES = 8;     // quiet cycles after the last result before a write
  localparam int REPORT_LIMIT  = 10;
  localparam int RANDOM_CHARS  = 1600;
  localparam int FULL_PAIRS    = 40;    // pairs sent at the largest capacity

  // one result transaction as the parser presents it
  typedef struct packed {
    htip_pkg::kind_t                  kind;
    logic [htip_pkg::CHAR_W-1:0]      data_byte;
    logic [htip_pkg::OUT_COUNT_W-1:0] byte_count;
  } parse_result_t;

  logic clk = 1'b0;
  logic rst_n;

  always #(HALF_PERIOD) clk = ~clk;

  htip_in_if  in_if ();
  htip_out_if out_if ();
  htip_cfg_if cfg_if ();

  hex_text_image_parser u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .cfg_chan (cfg_if)
  );

  // parser state as predicted by the testbench
  logic [htip_pkg::CAP_W-1:0]      capacity_q;
  htip_pkg::phase_t                scan_phase;
  logic [htip_pkg::POS_W-1:0]      prefix_pos;
  logic [3:0]                      high_nib;
  bit                              have_high;
  logic [htip_pkg::COUNT_BITS-1:0] byte_total;
  bit                              text_failed;

  parse_result_t expected_results[$];
  int            fault_count = 0;
  bit            quiet_mode;   // both sides stream with no gaps or stalls
  int            quiet_cycles;

  // ---------------------------------------------------------------------------
  // parse predictor
  // ---------------------------------------------------------------------------

  // digit value in the low four bits, bit 4 set for anything that is not hex
  function automatic logic [4:0] nibble_of(input logic [htip_pkg::CHAR_W-1:0] c);
    if (c >= 8'h30 && c <= 8'h39) return {1'b0, c[3:0]};
    // 'A'..'F' and 'a'..'f' both carry 1..6 in their low nibble
    if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) return 5'(c[3:0] + 4'd9);
    return 5'h10;
  endfunction

  function automatic bit is_blank(input logic [htip_pkg::CHAR_W-1:0] c);
    return c == 8'h20 || c == 8'h09 || c == 8'h0A || c == 8'h0D;
  endfunction

  function automatic void clear_text_state();
    scan_phase  = htip_pkg::PH_LEAD;
    prefix_pos  = '0;
    high_nib    = '0;
    have_high   = 1'b0;
    byte_total  = '0;
    text_failed = 1'b0;
  endfunction

  // one character of the hex body; returns 1 when a data byte comes out
  function automatic bit take_body_char(input logic [htip_pkg::CHAR_W-1:0] c,
                                        output parse_result_t r);
    logic [4:0] v;
    v = nibble_of(c);
    r = '0;
    if (!have_high) begin
      // blanks only between pairs
      if (is_blank(c)) return 1'b0;
      if (v[4]) begin
        text_failed = 1'b1;
        return 1'b0;
      end
      high_nib  = v[3:0];
      have_high = 1'b1;
      return 1'b0;
    end
    // a blank inside a pair lands here as a bad character
    if (v[4]) begin
      text_failed = 1'b1;
      return 1'b0;
    end
    // image full or counter at its top: the pair is refused
    if (byte_total >= capacity_q || byte_total == htip_pkg::COUNT_MAX) begin
      text_failed = 1'b1;
      return 1'b0;
    end
    byte_total  = byte_total + 1'b1;
    have_high   = 1'b0;
    r.kind       = htip_pkg::KIND_DATA;
    r.data_byte  = {high_nib, v[3:0]};
    r.byte_count = byte_total;
    high_nib    = '0;
    return 1'b1;
  endfunction

  // advances the predicted state by one character; returns 1 when a result is due
  function automatic bit predict_char(input logic [htip_pkg::CHAR_W-1:0] c,
                                      output parse_result_t r);
    r = '0;
    if (c == htip_pkg::CHAR_NUL) begin
      // verdict: ok only for a clean body with whole pairs and at least one byte
      r.kind = (!text_failed && scan_phase == htip_pkg::PH_BODY && !have_high &&
                byte_total != 0) ? htip_pkg::KIND_OK : htip_pkg::KIND_FAIL;
      r.byte_count = byte_total;
      clear_text_state();
      return 1'b1;
    end
    if (text_failed) return 1'b0;
    case (scan_phase)
      htip_pkg::PH_LEAD: begin
        if (is_blank(c)) return 1'b0;
        if (c == htip_pkg::CHAR_MAGIC0) begin
          scan_phase = htip_pkg::PH_PREFIX;
          prefix_pos = htip_pkg::POS_W'(1);
          return 1'b0;
        end
        scan_phase = htip_pkg::PH_BODY;
        return take_body_char(c, r);
      end
      htip_pkg::PH_PREFIX: begin
        if (c != htip_pkg::MAGIC[(htip_pkg::PREFIX_LEN - 1 - int'(prefix_pos)) * 8 +: 8])
        begin
          text_failed = 1'b1;
          return 1'b0;
        end
        prefix_pos = prefix_pos + 1'b1;
        if (prefix_pos == htip_pkg::PREFIX_LEN) scan_phase = htip_pkg::PH_BODY;
        return 1'b0;
      end
      default: begin
        return take_body_char(c, r);
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // monitors: prediction on every accepted transaction, result checking
  // ---------------------------------------------------------------------------

  // values are read at the rising edge, before any update made at that edge
  always @(posedge clk) begin : predict_accepted
    parse_result_t r;
    if (!rst_n) begin
      capacity_q = htip_pkg::CAP_RESET;
      clear_text_state();
    end else begin
      if (in_if.valid && in_if.ready) begin
        if (predict_char(in_if.text_char, r)) expected_results.push_back(r);
      end
      if (cfg_if.valid && cfg_if.ready) capacity_q = cfg_if.byte_capacity;
    end
  end

  function automatic void note_fault(input string what, input parse_result_t want,
                                     input parse_result_t got);
    fault_count++;
    if (fault_count <= REPORT_LIMIT) begin
      $display("%0t %s: expected kind %0d byte %02h count %0d,",
               $time, what, want.kind, want.data_byte, want.byte_count,
               " got kind %0d byte %02h count %0d",
               got.kind, got.data_byte, got.byte_count);
    end
  endfunction

  always @(posedge clk) begin : check_results
    parse_result_t want;
    parse_result_t got;
    if (rst_n && out_if.valid && out_if.ready) begin
      got.kind       = htip_pkg::kind_t'(out_if.kind);
      got.data_byte  = out_if.data_byte;
      got.byte_count = out_if.byte_count;
      if (expected_results.size() == 0) begin
        note_fault("result transaction with nothing pending", '0, got);
      end else begin
        want = expected_results.pop_front();
        if (got.kind !== want.kind || got.data_byte !== want.data_byte ||
            got.byte_count !== want.byte_count) begin
          note_fault("result mismatch", want, got);
        end
      end
    end
  end

  // ends the run when no channel moves a transaction for too long
  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------------------

  function automatic int unsigned draw_wait();
    return quiet_mode ? 0 : $urandom_range(0, MAX_WAIT);
  endfunction

  // result side: a fresh stall before every result transaction
  initial begin
    out_if.ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      int unsigned stall;
      stall = draw_wait();
      if (stall != 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk); while (!(out_if.valid && out_if.ready));
    end
  end

  // offers one character and returns at the edge that accepts it; valid stays
  // high so that back-to-back characters need no second assignment
  task automatic send_char(input logic [htip_pkg::CHAR_W-1:0] c);
    int unsigned gap;
    gap = draw_wait();
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid     <= 1'b1;
    in_if.text_char <= c;
    do @(posedge clk); while (!(in_if.valid && in_if.ready));
  endtask

  // sends a text and its terminator
  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
    send_char(htip_pkg::CHAR_NUL);
  endtask

  // stops offering, waits for every pending result and lets the pipeline drain
  task automatic settle_idle();
    in_if.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [htip_pkg::CAP_W-1:0] cap);
    settle_idle();
    cfg_if.valid         <= 1'b1;
    cfg_if.byte_capacity <= cap;
    do @(posedge clk); while (!(cfg_if.valid && cfg_if.ready));
    cfg_if.valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // text generation
  // ---------------------------------------------------------------------------

  function automatic logic [htip_pkg::CHAR_W-1:0] pick_digit();
    int unsigned v;
    v = $urandom_range(0, 15);
    if (v < 10) return 8'(8'h30 + v);
    return 8'(($urandom_range(0, 1) ? 8'h61 : 8'h41) + v - 10);
  endfunction

  function automatic logic [htip_pkg::CHAR_W-1:0] pick_blank();
    case ($urandom_range(0, 3))
      0: return 8'h20;
      1: return 8'h09;
      2: return 8'h0A;
      default: return 8'h0D;
    endcase
  endfunction

  // mostly well-formed texts with random content; some noise, some broken on purpose
  function automatic void build_text(ref logic [htip_pkg::CHAR_W-1:0] text[$]);
    int unsigned style;
    int unsigned pairs;
    int unsigned at;
    int unsigned cut;
    text.delete();
    style = $urandom_range(0, 11);
    if (style == 0) begin
      // noise: any nonzero character
      repeat ($urandom_range(1, 12)) text.push_back(8'($urandom_range(1, 255)));
    end else begin
      repeat ($urandom_range(0, 2)) text.push_back(pick_blank());
      if (style == 1) begin
        // prefix cut short, the data follows straight on
        cut = $urandom_range(1, htip_pkg::PREFIX_LEN - 1);
        for (int i = 0; i < cut; i++)
          text.push_back(htip_pkg::MAGIC[(htip_pkg::PREFIX_LEN - 1 - i) * 8 +: 8]);
      end else if ($urandom_range(0, 1)) begin
        for (int i = 0; i < htip_pkg::PREFIX_LEN; i++)
          text.push_back(htip_pkg::MAGIC[(htip_pkg::PREFIX_LEN - 1 - i) * 8 +: 8]);
        if ($urandom_range(0, 1)) text.push_back(pick_blank());
      end
      pairs = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 40) : $urandom_range(1, 6);
      repeat (pairs) begin
        text.push_back(pick_digit());
        text.push_back(pick_digit());
        if ($urandom_range(0, 2) == 0) text.push_back(pick_blank());
      end
      // broken texts: a stray character, a dropped one or a blank pushed in
      if ((style == 2 || style == 3) && text.size() != 0) begin
        at = $urandom_range(0, text.size() - 1);
        case ($urandom_range(0, 2))
          0: text[at] = 8'($urandom_range(1, 255));
          1: text.delete(at);
          default: text.insert(at, pick_blank());
        endcase
      end
    end
    text.push_back(htip_pkg::CHAR_NUL);
  endfunction

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // the special cases at the reset capacity
  task automatic test_directed_texts();
    send_text("");                    // empty text: zero bytes
    send_text("MARSX");               // prefix broken after the first letters
    send_text(" fF\tA");              // byte ff, blank between pairs, then a lone digit
    send_text("0 1");                 // blank inside a pair
    send_text("\377");                // all-ones character at the first position
    send_text("\tMARSHEX");           // prefix with no data after it
    send_text("MARSHEX\015\n00");     // byte 00 after prefix and blanks: ok
  endtask

  // image exactly full, and one byte beyond it
  task automatic test_capacity_limits();
    write_capacity(16'd1);
    send_text("aa bb");
    send_text("5c");
    write_capacity(16'd3);
    send_text("010203");
  endtask

  // largest capacity with both sides streaming
  task automatic test_full_capacity();
    quiet_mode = 1'b1;
    write_capacity(16'hFFFF);
    repeat (FULL_PAIRS) begin
      send_char(pick_digit());
      send_char(pick_digit());
    end
    send_char(htip_pkg::CHAR_NUL);
    quiet_mode = 1'b0;
  endtask

  task automatic test_random_texts();
    logic [htip_pkg::CHAR_W-1:0] text[$];
    int                          sent;
    sent = 0;
    while (sent < RANDOM_CHARS) begin
      if ($urandom_range(0, 7) == 0) begin
        case ($urandom_range(0, 3))
          0, 1: write_capacity(16'($urandom_range(1, 8)));
          2: write_capacity(16'($urandom_range(1, 16'hFFFF)));
          default: write_capacity(16'hFFFF);
        endcase
      end
      // some texts run with both sides streaming
      quiet_mode = ($urandom_range(0, 3) == 0);
      build_text(text);
      foreach (text[i]) begin
        // now and then hold off until every pending result is out
        if ($urandom_range(0, 199) == 0) settle_idle();
        send_char(text[i]);
      end
      sent += text.size();
    end
    quiet_mode = 1'b0;
  endtask

  initial begin
    rst_n                <= 1'b0;
    in_if.valid          <= 1'b0;
    in_if.text_char      <= htip_pkg::CHAR_NUL;
    cfg_if.valid         <= 1'b0;
    cfg_if.byte_capacity <= '0;
    quiet_mode = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_texts();
    test_capacity_limits();
    test_random_texts();
    test_full_capacity();

    settle_idle();
    if (fault_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
